// ===== hw/rtl/apnh_pkg.sv =====
// ----------------------------------------------------------------------------
// apnh_pkg
// Shared types, constants and helper functions of the archive path name hash.
// ----------------------------------------------------------------------------
package apnh_pkg;

  localparam int MAX_LEN = 255;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [31:0] MUL_K = 32'h0001_003F;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  localparam logic [23:0] EXT_KF  = 24'h2E6B66;
  localparam logic [31:0] EXT_NIF = 32'h2E6E6966;
  localparam logic [31:0] EXT_DDS = 32'h2E646473;
  localparam logic [31:0] EXT_WAV = 32'h2E776176;

  localparam logic [31:0] FLAG_KF  = 32'h0000_0080;
  localparam logic [31:0] FLAG_NIF = 32'h0000_8000;
  localparam logic [31:0] FLAG_DDS = 32'h0000_8080;
  localparam logic [31:0] FLAG_WAV = 32'h8000_0000;

  typedef struct packed {
    logic [63:0] name_hash;
    logic        too_long;
  } apnh_result_t;

  // Lowercase ASCII letters and turn forward slash into backslash.
  function automatic logic [7:0] fold_char(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CASE_BIT;
    if (c == CH_SLASH) c = CH_BSLASH;
    return c;
  endfunction

  // One multiply-add hash step, modulo 2^32.
  function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] c);
    return h * MUL_K + {24'd0, c};
  endfunction

endpackage

// ===== hw/rtl/apnh_state.sv =====
// ----------------------------------------------------------------------------
// apnh_state
// Per-path hash state: takes one beat per step and forms the final hash.
// ----------------------------------------------------------------------------
module apnh_state (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            path_byte,
  input  logic                  no_char,
  input  logic                  last,
  output apnh_pkg::apnh_result_t result
);
  import apnh_pkg::*;

  typedef struct packed {
    cnt_t        count;
    logic [7:0]  first_char;
    logic [15:0] recent;
    logic [31:0] lagged;
    cnt_t        saved_len;
    logic [31:0] saved_lo;
    logic [31:0] saved_mid;
    logic        dot_seen;
    logic [31:0] ext_hash;
    logic [31:0] ext_chars;
    cnt_t        ext_len;
    logic        overflow;
  } state_t;

  state_t st;
  state_t st_next;

  function automatic logic [31:0] low_word(input cnt_t n, input logic [15:0] rc,
                                           input logic [7:0] fc);
    logic [7:0] second;
    second = (n > cnt_t'(2)) ? rc[15:8] : 8'h00;
    if (n == '0) return 32'd0;
    return {fc, 8'(n), second, rc[7:0]};
  endfunction

  logic [7:0]  c;
  cnt_t        p;
  logic [31:0] lo;
  logic [31:0] mid;
  logic [31:0] ext;

  always_comb begin
    st_next = st;
    c       = fold_char(path_byte);
    p       = st.count;
    if (!no_char) begin
      if (p >= cnt_t'(MAX_LEN)) begin
        st_next.overflow = 1'b1;
      end else begin
        if (c == CH_DOT) begin
          st_next.saved_len = p;
          st_next.saved_lo  = low_word(p, st.recent, st.first_char);
          st_next.saved_mid = st.lagged;
          st_next.dot_seen  = 1'b1;
          st_next.ext_hash  = {24'd0, c};
          st_next.ext_chars = {24'd0, c};
          st_next.ext_len   = cnt_t'(1);
        end else if (st.dot_seen) begin
          // extension length never passes the char count, so no wrap
          st_next.ext_hash  = mix(st.ext_hash, c);
          st_next.ext_chars = {st.ext_chars[23:0], c};
          st_next.ext_len   = st.ext_len + cnt_t'(1);
        end
        if (p == '0) st_next.first_char = c;
        if (p >= cnt_t'(3)) st_next.lagged = mix(st.lagged, st.recent[15:8]);
        st_next.recent = {st.recent[7:0], c};
        st_next.count  = p + cnt_t'(1);
      end
    end

    // final hash from the updated state
    ext = 32'd0;
    if (st_next.dot_seen) begin
      lo  = st_next.saved_lo;
      mid = (st_next.saved_len > cnt_t'(3)) ? st_next.saved_mid : 32'd0;
      ext = st_next.ext_hash;
      if (st_next.ext_len == cnt_t'(3) && st_next.ext_chars[23:0] == EXT_KF) begin
        lo = lo | FLAG_KF;
      end else if (st_next.ext_len == cnt_t'(4)) begin
        if (st_next.ext_chars == EXT_NIF)      lo = lo | FLAG_NIF;
        else if (st_next.ext_chars == EXT_DDS) lo = lo | FLAG_DDS;
        else if (st_next.ext_chars == EXT_WAV) lo = lo | FLAG_WAV;
      end
    end else begin
      lo  = low_word(st_next.count, st_next.recent, st_next.first_char);
      mid = (st_next.count > cnt_t'(3)) ? st_next.lagged : 32'd0;
    end
    result.name_hash = {mid + ext, lo};
    result.too_long  = st_next.overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= last ? state_t'('0) : st_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    st.count <= cnt_t'(MAX_LEN))
    else $error("char count passed the maximum path length");

  a_ext_in_path: assert property (@(posedge clk) disable iff (rst)
    st.dot_seen |-> (st.saved_len + st.ext_len == st.count))
    else $error("name and extension lengths do not add up to the path");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (step && last) |=> (st.count == '0 && !st.overflow && !st.dot_seen))
    else $error("state not cleared after the final beat");
`endif

endmodule

// ===== hw/rtl/archive_path_name_hash_core.sv =====
// ----------------------------------------------------------------------------
// archive_path_name_hash_core
// Streaming 64-bit archive name hash of a path, one byte per beat.
// ----------------------------------------------------------------------------
// The path streams in one byte per input beat; the beat with last set closes
// the path and yields one result beat holding the 64-bit name hash and the
// too_long flag. A beat with no_char set carries no character (pair it with
// last to close an empty path, which hashes to zero). The core takes one beat
// every cycle while in_stall is low: an input register feeds a single stage
// of hash logic (one constant multiply-add per byte) whose output goes to a
// result register that loads as the final beat leaves it. in_stall
// rises only while a final beat sits in the input register and the result
// register still holds an earlier result that the sink is stalling; bytes
// that do not end a path keep flowing even then. Characters past MAX_LEN are
// dropped and flagged through too_long.
module archive_path_name_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  path_byte,
  input  logic        no_char,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] name_hash,
  output logic        too_long
);
  import apnh_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_no_char;
  logic       s1_last;
  logic       s1_go;

  apnh_result_t result;

  // A non-final beat always advances; a final beat needs room in the
  // result register.
  assign s1_go    = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // hold payload while stalled, capture on every accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte    <= path_byte;
      s1_no_char <= no_char;
      s1_last    <= last;
    end
  end

  apnh_state u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .path_byte (s1_byte),
    .no_char   (s1_no_char),
    .last      (s1_last),
    .result    (result)
  );

  // result register: load on a final beat, drop once the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      name_hash <= result.name_hash;
      too_long  <= result.too_long;
    end
  end

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && out_valid && out_stall))
    else $error("input stalled without a blocked final beat");

  a_last_loads: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> out_valid)
    else $error("final beat did not produce a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(s1_valid && s1_last))
    else $error("result appeared without a final beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(s1_go && s1_last))
    else $error("pending result would be overwritten");
`endif

endmodule
